FILE: rtl/core/lgs_pkg.sv
package lgs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RESET_DIM  = 64;

    localparam int COORD_W   = 10;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int WIN_W     = 9;
    localparam int CNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

    // result slots of one queue entry, sent lowest first
    localparam int RES_A   = 0;  // interior/left-edge cell (x-1, y-1)
    localparam int RES_B   = 1;  // last column of previous row (x, y-1)
    localparam int RES_C   = 2;  // last row passthrough (x, y)
    localparam int NUM_RES = 3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [NUM_RES-1:0] t_res_mask;

    typedef struct packed {
        t_coord    x;
        t_coord    y;
        t_res_mask mask;
        logic      a_alive;
        logic      a_changed;
        logic      b_alive;
        logic      c_alive;
        logic      eof;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // register value -> last valid index, zero taken as one, saturated at maxv
    function automatic t_coord dim_to_last(input logic [DIM_W-1:0] v, input int maxv);
        t_coord r;
        if (v == '0) begin
            r = '0;
        end else if (int'(v) > maxv) begin
            r = t_coord'(maxv - 1);
        end else begin
            r = t_coord'(v - 1'b1);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] popcount9(input logic [WIN_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WIN_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/life_generation_stencil_core.sv
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_stall    | i_cell_alive
// output  | out       | o_out_valid / i_out_stall  | o_cell_x, o_cell_y, o_alive_next,
//         |           |                            | o_changed, o_last_of_run, o_end_of_frame
// config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Cycles: one cell transaction per clock while each cell yields at most one result and
//   the output is not stalled; the output register sends one result per clock unless
//   stalled. A last-column cell yields two results, absorbed by the 4-entry queue. In
//   the last row every cell but column 0 yields two (three at the corner), so once the
//   queue fills the input stalls. Results pass the front stage, queue and output register.
// Reset: synchronous, active low; counters, window, queue and output valid clear.
//   Row buffer is not cleared (no clearing pass); entries are written before use.
// Stalls: output stall backs up the queue, then the front stage, then o_in_stall.
module life_generation_stencil_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lgs_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cell_alive,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lgs_pkg::COORD_W-1:0]   o_cell_x,
    output logic [lgs_pkg::COORD_W-1:0]   o_cell_y,
    output logic                         o_alive_next,
    output logic                         o_changed,
    output logic                         o_last_of_run,
    output logic                         o_end_of_frame
);
    import lgs_pkg::*;

    // front -> queue
    logic      push;
    t_entry    push_entry;
    // queue -> back
    t_entry    head_entry;
    t_q_status q_status;
    logic      pop;

    // Front: raster counters, 2-bit row buffer (rows y-2 and y-1), 3x3 window
    // and B3/S23 rule; packs up to three results for one cell into one entry.
    lgs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cell_alive (i_cell_alive),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_q_status   (q_status)
    );

    // Short decoupling queue; entries with no result are never pushed.
    lgs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    // Back: walks the head entry's result slots in order, one per clock unless the
    // output is stalled, into the output register; flags last_of_run / end_of_frame.
    lgs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (head_entry),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cell_x       (o_cell_x),
        .o_cell_y       (o_cell_y),
        .o_alive_next   (o_alive_next),
        .o_changed      (o_changed),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

FILE: rtl/core/lgs_front.sv
module lgs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lgs_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cell_alive,
    output logic                         o_push,
    output lgs_pkg::t_entry              o_entry,
    input  lgs_pkg::t_q_status           i_q_status
);
    import lgs_pkg::*;

    t_coord r_w_last, r_h_last;
    t_coord r_col, r_row;
    t_coord r_s1_x, r_s1_y;
    logic   r_s1_valid, r_s1_c;
    logic   r_fwd;
    logic [1:0] r_fwd_data, r_rd;
    logic [WIN_W-1:0] r_win;
    // {row y-2, row y-1} per column
    logic [1:0] r_rowbuf [MAX_WIDTH];

    logic accept, s1_adv;
    logic above, above2, cur, nxt;
    logic [1:0] prev;
    logic [WIN_W-1:0] n_win;
    logic [CNT_W-1:0] nb;
    t_res_mask mask;
    t_coord n_col, n_row;

    always_comb begin
        prev   = r_fwd ? r_fwd_data : r_rd;
        above2 = prev[1];
        above  = prev[0];
        n_win  = {r_win[WIN_W-4:0], r_s1_c, above, above2};
        cur    = n_win[4];
        nb     = popcount9(n_win) - CNT_W'(cur);
        if (r_s1_x > t_coord'(1) && r_s1_y > t_coord'(1)) begin
            nxt = (nb == BIRTH_COUNT) || (cur && nb == SURVIVE_COUNT);
        end else begin
            nxt = cur;
        end
        mask[RES_A] = (r_s1_y != '0) && (r_s1_x != '0);
        mask[RES_B] = (r_s1_y != '0) && (r_s1_x == r_w_last);
        mask[RES_C] = (r_s1_y == r_h_last);

        o_entry.x         = r_s1_x;
        o_entry.y         = r_s1_y;
        o_entry.mask      = mask;
        o_entry.a_alive   = nxt;
        o_entry.a_changed = nxt ^ cur;
        o_entry.b_alive   = above;
        o_entry.c_alive   = r_s1_c;
        o_entry.eof       = (r_s1_x == r_w_last) && (r_s1_y == r_h_last);

        s1_adv     = r_s1_valid && ((mask == '0) || !i_q_status.full);
        o_push     = r_s1_valid && (mask != '0) && !i_q_status.full;
        o_in_stall = r_s1_valid && !s1_adv;
        accept     = i_in_valid && !o_in_stall;

        if (r_col == r_w_last) begin
            n_col = '0;
            n_row = (r_row == r_h_last) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= dim_to_last(DIM_W'(RESET_DIM), MAX_WIDTH);
            r_h_last   <= dim_to_last(DIM_W'(RESET_DIM), MAX_HEIGHT);
            r_col      <= '0;
            r_row      <= '0;
            r_win      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GRID_WIDTH:  r_w_last <= dim_to_last(i_cfg_data, MAX_WIDTH);
                    REG_GRID_HEIGHT: r_h_last <= dim_to_last(i_cfg_data, MAX_HEIGHT);
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
                r_win <= '0;
            end else begin
                if (accept) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end
                if (s1_adv) begin
                    r_win <= n_win;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                // one column wide grid: read and write hit the same entry
                r_fwd      <= s1_adv && (r_s1_x == r_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_c     <= i_cell_alive;
            r_s1_x     <= r_col;
            r_s1_y     <= r_row;
            r_fwd_data <= {above, r_s1_c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_rowbuf[r_s1_x] <= {above, r_s1_c};
        end
        if (accept) begin
            r_rd <= r_rowbuf[r_col];
        end
    end

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_w_last) && (r_row <= r_h_last))
        else $error("raster counter beyond grid");

endmodule

FILE: rtl/core/lgs_queue.sv
module lgs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lgs_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output lgs_pkg::t_entry    o_entry,
    output lgs_pkg::t_q_status o_status
);
    import lgs_pkg::*;

    t_entry r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_entry;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/lgs_back.sv
module lgs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lgs_pkg::t_entry            i_entry,
    input  lgs_pkg::t_q_status         i_q_status,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lgs_pkg::COORD_W-1:0] o_cell_x,
    output logic [lgs_pkg::COORD_W-1:0] o_cell_y,
    output logic                       o_alive_next,
    output logic                       o_changed,
    output logic                       o_last_of_run,
    output logic                       o_end_of_frame
);
    import lgs_pkg::*;

    t_res_mask r_done;
    logic      r_out_valid;
    t_coord    r_out_x, r_out_y;
    logic      r_out_alive, r_out_changed, r_out_last, r_out_eof;

    t_res_mask pending, sel;
    logic      out_load, last;
    t_coord    n_x, n_y;
    logic      n_alive, n_changed;

    always_comb begin
        pending = i_entry.mask & ~r_done;
        sel     = pending & (~pending + 1'b1);
        last    = ((pending & ~sel) == '0);
        if (sel[RES_A]) begin
            n_x       = i_entry.x - 1'b1;
            n_y       = i_entry.y - 1'b1;
            n_alive   = i_entry.a_alive;
            n_changed = i_entry.a_changed;
        end else if (sel[RES_B]) begin
            n_x       = i_entry.x;
            n_y       = i_entry.y - 1'b1;
            n_alive   = i_entry.b_alive;
            n_changed = 1'b0;
        end else begin
            n_x       = i_entry.x;
            n_y       = i_entry.y;
            n_alive   = i_entry.c_alive;
            n_changed = 1'b0;
        end
        out_load = !i_q_status.empty && (!r_out_valid || !i_out_stall);
        o_pop    = out_load && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_done      <= last ? '0 : (r_done | sel);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x       <= n_x;
            r_out_y       <= n_y;
            r_out_alive   <= n_alive;
            r_out_changed <= n_changed;
            r_out_last    <= last;
            r_out_eof     <= last && i_entry.eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_x       = r_out_x;
    assign o_cell_y       = r_out_y;
    assign o_alive_next   = r_out_alive;
    assign o_changed      = r_out_changed;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

    a_done_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> !i_q_status.empty)
        else $error("partial entry progress without a queued entry");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> ((r_done & ~i_entry.mask) == '0) && (pending != '0))
        else $error("sent-result mask inconsistent with head entry");

endmodule
